>>> rtl/core/iole_pkg.sv
// Shared codes, types and default sizes for the indexed ordered list engine.
package iole_pkg;

	localparam int CAPACITY_DEF   = 64;
	localparam int DATA_WIDTH_DEF = 32;

	localparam logic [1:0] REQ_INSERT  = 2'd0;
	localparam logic [1:0] REQ_DELETE  = 2'd1;
	localparam logic [1:0] REQ_REVERSE = 2'd2;
	localparam logic [1:0] REQ_QUERY   = 2'd3;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic val;
		logic nxt;
		logic prv;
	} node_we_t;

endpackage

>>> rtl/core/iole_node_mem.sv
// Node memory holding the value and both links of every list slot.
module iole_node_mem import iole_pkg::*; #(
	parameter int CAPACITY   = CAPACITY_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF,
	localparam int AW = $clog2(CAPACITY),
	localparam int SW = $clog2(CAPACITY) + 1
) (
	input  logic                  clk,
	input  logic                  rd_en,
	input  logic [AW-1:0]         rd_addr,
	output logic [DATA_WIDTH-1:0] rd_val,
	output logic [SW-1:0]         rd_next,
	output logic [SW-1:0]         rd_prev,
	input  node_we_t              we,
	input  logic [AW-1:0]         wr_addr,
	input  logic [DATA_WIDTH-1:0] wr_val,
	input  logic [SW-1:0]         wr_next,
	input  logic [SW-1:0]         wr_prev
);

	logic [DATA_WIDTH-1:0] val_mem  [CAPACITY];
	logic [SW-1:0]         next_mem [CAPACITY];
	logic [SW-1:0]         prev_mem [CAPACITY];

	always_ff @(posedge clk) begin
		if (we.val) begin
			val_mem[wr_addr] <= wr_val;
		end
		if (we.nxt) begin
			next_mem[wr_addr] <= wr_next;
		end
		if (we.prv) begin
			prev_mem[wr_addr] <= wr_prev;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_val  <= val_mem[rd_addr];
			rd_next <= next_mem[rd_addr];
			rd_prev <= prev_mem[rd_addr];
		end
	end

endmodule

>>> rtl/core/iole_free_mem.sv
// Stack memory of released node slots.
module iole_free_mem import iole_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF,
	localparam int AW = $clog2(CAPACITY)
) (
	input  logic          clk,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [AW-1:0] rd_data,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [AW-1:0] wr_data
);

	logic [AW-1:0] stack_mem [CAPACITY];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			stack_mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= stack_mem[rd_addr];
		end
	end

endmodule

>>> rtl/core/iole_ctrl.sv
// Request sequencer that walks and relinks the list through the memories.
module iole_ctrl import iole_pkg::*; #(
	parameter int CAPACITY   = CAPACITY_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF,
	localparam int AW = $clog2(CAPACITY),
	localparam int SW = $clog2(CAPACITY) + 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [1:0]            req_type,
	input  logic [6:0]            position,
	input  logic signed [31:0]    new_value,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [1:0]            status,
	output logic signed [31:0]    removed_value,
	output logic [6:0]            item_count,
	output logic signed [31:0]    item_sum,
	output logic                  node_rd_en,
	output logic [AW-1:0]         node_rd_addr,
	input  logic [DATA_WIDTH-1:0] node_rd_val,
	input  logic [SW-1:0]         node_rd_next,
	input  logic [SW-1:0]         node_rd_prev,
	output node_we_t              node_we,
	output logic [AW-1:0]         node_wr_addr,
	output logic [DATA_WIDTH-1:0] node_wr_val,
	output logic [SW-1:0]         node_wr_next,
	output logic [SW-1:0]         node_wr_prev,
	output logic                  free_rd_en,
	output logic [AW-1:0]         free_rd_addr,
	input  logic [AW-1:0]         free_rd_data,
	output logic                  free_wr_en,
	output logic [AW-1:0]         free_wr_addr,
	output logic [AW-1:0]         free_wr_data
);

	localparam int LW = $clog2(CAPACITY + 1);
	localparam int CW = (LW > 7) ? LW : 7;
	localparam int VW = (DATA_WIDTH > 32) ? DATA_WIDTH : 32;
	localparam logic [SW-1:0] NIL = SW'(CAPACITY);
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_ALLOC = 3'd1;
	localparam logic [2:0] S_RD    = 3'd2;
	localparam logic [2:0] S_CHK   = 3'd3;
	localparam logic [2:0] S_WNODE = 3'd4;
	localparam logic [2:0] S_WP    = 3'd5;
	localparam logic [2:0] S_WN    = 3'd6;
	localparam logic [2:0] S_DONE  = 3'd7;

	logic [2:0]            state_q;
	logic [1:0]            op_q;
	logic [1:0]            st_q;
	logic [CW-1:0]         cnt_q;
	logic [SW-1:0]         cur_q;
	logic [SW-1:0]         slot_q;
	logic [SW-1:0]         p_q;
	logic [SW-1:0]         n_q;
	logic [DATA_WIDTH-1:0] val_q;
	logic [DATA_WIDTH-1:0] rem_q;
	logic [SW-1:0]         head_q;
	logic [SW-1:0]         tail_q;
	logic [LW-1:0]         free_top_q;
	logic [LW-1:0]         fresh_q;
	logic [LW-1:0]         len_q;
	logic [DATA_WIDTH-1:0] total_q;
	logic                  out_valid_q;
	logic [1:0]            status_q;
	logic [31:0]           removed_q;
	logic [6:0]            count_q;
	logic [31:0]           sum_q;

	logic                  accept;
	logic [CW-1:0]         pos_c;
	logic [CW-1:0]         len_c;
	logic [VW-1:0]         in_ext;
	logic [VW-1:0]         rem_ext;
	logic [VW-1:0]         sum_ext;
	logic [CW-1:0]         len_out;
	logic [LW-1:0]         len_next;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);
	assign pos_c    = CW'(position);
	assign len_c    = CW'(len_q);
	assign in_ext   = VW'(new_value);
	assign rem_ext  = VW'(rem_q);
	assign sum_ext  = VW'(total_q);
	assign len_out  = CW'(len_q);
	assign len_next = len_q;

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign removed_value = removed_q;
	assign item_count    = count_q;
	assign item_sum      = sum_q;

	always_comb begin
		node_rd_en   = (state_q == S_RD);
		node_rd_addr = cur_q[AW-1:0];
		node_we      = '0;
		node_wr_addr = slot_q[AW-1:0];
		node_wr_val  = val_q;
		node_wr_next = n_q;
		node_wr_prev = p_q;
		free_rd_en   = accept;
		free_rd_addr = AW'(free_top_q - 1'b1);
		free_wr_en   = 1'b0;
		free_wr_addr = free_top_q[AW-1:0];
		free_wr_data = slot_q[AW-1:0];
		case (state_q)
			S_CHK: begin
				if (op_q == REQ_REVERSE) begin
					node_we.nxt  = 1'b1;
					node_we.prv  = 1'b1;
					node_wr_addr = cur_q[AW-1:0];
					node_wr_next = node_rd_prev;
					node_wr_prev = node_rd_next;
				end
			end
			S_WNODE: begin
				node_we = '{val: 1'b1, nxt: 1'b1, prv: 1'b1};
			end
			S_WP: begin
				node_we.nxt  = (p_q != NIL);
				node_wr_addr = p_q[AW-1:0];
				node_wr_next = (op_q == REQ_INSERT) ? slot_q : n_q;
			end
			S_WN: begin
				node_we.prv  = (n_q != NIL);
				node_wr_addr = n_q[AW-1:0];
				node_wr_prev = (op_q == REQ_INSERT) ? slot_q : p_q;
				free_wr_en   = (op_q == REQ_DELETE) && (CW'(free_top_q) < CAP_C);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= NIL;
			tail_q      <= NIL;
			free_top_q  <= '0;
			fresh_q     <= '0;
			len_q       <= '0;
			total_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						st_q  <= ST_OK;
						rem_q <= '0;
						cur_q <= head_q;
						case (req_type)
							REQ_INSERT: begin
								cnt_q <= pos_c;
								if (pos_c > len_c) begin
									st_q    <= ST_RANGE;
									state_q <= S_DONE;
								end else if (len_c >= CAP_C) begin
									st_q    <= ST_FULL;
									state_q <= S_DONE;
								end else begin
									state_q <= S_ALLOC;
								end
							end
							REQ_DELETE: begin
								cnt_q <= pos_c;
								if (pos_c == '0 || pos_c > len_c) begin
									st_q    <= ST_RANGE;
									state_q <= S_DONE;
								end else begin
									state_q <= S_RD;
								end
							end
							REQ_REVERSE: begin
								cnt_q   <= len_c;
								state_q <= (len_q == '0) ? S_DONE : S_RD;
							end
							default: begin
								state_q <= S_DONE;
							end
						endcase
						op_q  <= req_type;
						val_q <= in_ext[DATA_WIDTH-1:0];
					end
				end
				S_ALLOC: begin
					if (free_top_q != '0) begin
						slot_q     <= SW'(free_rd_data);
						free_top_q <= free_top_q - 1'b1;
					end else begin
						slot_q  <= SW'(fresh_q);
						fresh_q <= fresh_q + 1'b1;
					end
					if (cnt_q == '0) begin
						p_q     <= NIL;
						n_q     <= head_q;
						state_q <= S_WNODE;
					end else begin
						state_q <= S_RD;
					end
				end
				S_RD: begin
					state_q <= S_CHK;
				end
				S_CHK: begin
					cur_q <= node_rd_next;
					cnt_q <= cnt_q - 1'b1;
					if (op_q == REQ_REVERSE) begin
						if (cnt_q == CW'(1)) begin
							head_q  <= tail_q;
							tail_q  <= head_q;
							state_q <= S_DONE;
						end else begin
							state_q <= S_RD;
						end
					end else if (cnt_q == CW'(1)) begin
						if (op_q == REQ_INSERT) begin
							p_q     <= cur_q;
							n_q     <= node_rd_next;
							state_q <= S_WNODE;
						end else begin
							slot_q  <= cur_q;
							p_q     <= node_rd_prev;
							n_q     <= node_rd_next;
							rem_q   <= node_rd_val;
							state_q <= S_WP;
						end
					end else begin
						state_q <= S_RD;
					end
				end
				S_WNODE: begin
					state_q <= S_WP;
				end
				S_WP: begin
					if (p_q == NIL) begin
						head_q <= (op_q == REQ_INSERT) ? slot_q : n_q;
					end
					state_q <= S_WN;
				end
				S_WN: begin
					if (n_q == NIL) begin
						tail_q <= (op_q == REQ_INSERT) ? slot_q : p_q;
					end
					if (op_q == REQ_INSERT) begin
						len_q   <= len_next + 1'b1;
						total_q <= total_q + val_q;
					end else begin
						len_q   <= len_next - 1'b1;
						total_q <= total_q - rem_q;
						if (CW'(free_top_q) < CAP_C) begin
							free_top_q <= free_top_q + 1'b1;
						end
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						status_q    <= st_q;
						removed_q   <= rem_ext[31:0];
						count_q     <= len_out[6:0];
						sum_q       <= sum_ext[31:0];
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

>>> rtl/core/indexed_ordered_list_engine_unit.sv
// Top level of the indexed ordered list engine.
// The block keeps an ordered list of signed values in a node memory with a
// free slot stack. Each input item is a request: insert a value before a
// position, delete the element at a position, reverse the list, or query.
// Each request gives exactly one result item with a status, the removed
// value, the element count and the wrapping sum of all elements.
// Both channels use valid and stall; an item moves when valid is high and
// stall is low. The input side stalls while a request is in progress.
// A query goes straight to its result. An insert or a delete walks the links
// from the head to its position, reading one node at a time through the
// single read port of the node memory; a reverse walks the whole list and
// swaps the two links of each node that it reads.
// A result waits in the output register while the receiver stalls; the
// sequencer holds its finished request until that register is free.
// Reset empties the list at once; no memory clearing pass is needed.
module indexed_ordered_list_engine_unit import iole_pkg::*; #(
	parameter int CAPACITY   = CAPACITY_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         req_type,
	input  logic [6:0]         position,
	input  logic signed [31:0] new_value,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         status,
	output logic signed [31:0] removed_value,
	output logic [6:0]         item_count,
	output logic signed [31:0] item_sum
);

	localparam int AW = $clog2(CAPACITY);
	localparam int SW = $clog2(CAPACITY) + 1;

	logic                  node_rd_en;
	logic [AW-1:0]         node_rd_addr;
	logic [DATA_WIDTH-1:0] node_rd_val;
	logic [SW-1:0]         node_rd_next;
	logic [SW-1:0]         node_rd_prev;
	node_we_t              node_we;
	logic [AW-1:0]         node_wr_addr;
	logic [DATA_WIDTH-1:0] node_wr_val;
	logic [SW-1:0]         node_wr_next;
	logic [SW-1:0]         node_wr_prev;
	logic                  free_rd_en;
	logic [AW-1:0]         free_rd_addr;
	logic [AW-1:0]         free_rd_data;
	logic                  free_wr_en;
	logic [AW-1:0]         free_wr_addr;
	logic [AW-1:0]         free_wr_data;

	iole_node_mem #(.CAPACITY(CAPACITY), .DATA_WIDTH(DATA_WIDTH)) u_node_mem (
		.clk     (clk),
		.rd_en   (node_rd_en),
		.rd_addr (node_rd_addr),
		.rd_val  (node_rd_val),
		.rd_next (node_rd_next),
		.rd_prev (node_rd_prev),
		.we      (node_we),
		.wr_addr (node_wr_addr),
		.wr_val  (node_wr_val),
		.wr_next (node_wr_next),
		.wr_prev (node_wr_prev)
	);

	iole_free_mem #(.CAPACITY(CAPACITY)) u_free_mem (
		.clk     (clk),
		.rd_en   (free_rd_en),
		.rd_addr (free_rd_addr),
		.rd_data (free_rd_data),
		.wr_en   (free_wr_en),
		.wr_addr (free_wr_addr),
		.wr_data (free_wr_data)
	);

	iole_ctrl #(.CAPACITY(CAPACITY), .DATA_WIDTH(DATA_WIDTH)) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.req_type      (req_type),
		.position      (position),
		.new_value     (new_value),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.status        (status),
		.removed_value (removed_value),
		.item_count    (item_count),
		.item_sum      (item_sum),
		.node_rd_en    (node_rd_en),
		.node_rd_addr  (node_rd_addr),
		.node_rd_val   (node_rd_val),
		.node_rd_next  (node_rd_next),
		.node_rd_prev  (node_rd_prev),
		.node_we       (node_we),
		.node_wr_addr  (node_wr_addr),
		.node_wr_val   (node_wr_val),
		.node_wr_next  (node_wr_next),
		.node_wr_prev  (node_wr_prev),
		.free_rd_en    (free_rd_en),
		.free_rd_addr  (free_rd_addr),
		.free_rd_data  (free_rd_data),
		.free_wr_en    (free_wr_en),
		.free_wr_addr  (free_wr_addr),
		.free_wr_data  (free_wr_data)
	);

endmodule

>>> rtl/core/iole_checker.sv
// Port-level checks of the list engine and their binding to the top level.
module iole_checker import iole_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [1:0]  status,
	input logic [31:0] removed_value
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(removed_value))
		else $error("Stalled result item changed.");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status <= ST_FULL)
		else $error("Result item carries an unknown status.");

	a_error_no_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> removed_value == 32'd0)
		else $error("Failed request returned a removed value.");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("Input was not stalled while a request is in progress.");

endmodule

bind indexed_ordered_list_engine_unit iole_checker u_iole_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_stall      (in_stall),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.status        (status),
	.removed_value (removed_value)
);
